### design/igat_pkg.sv
package igat_pkg;

  // Table geometry
  localparam int NUM_ROWS = 1024;
  localparam int NUM_COLS = 4;
  localparam int ROW_W    = $clog2(NUM_ROWS);
  localparam int RCNT_W   = ROW_W + 1;
  localparam int COL_W    = 2;
  localparam int SUM_W    = 48;
  localparam int CNT_W    = 16;
  localparam int VAL_W    = 32;
  localparam int STEP_W   = 6;
  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(SUM_W);

  // Item operations
  localparam logic [2:0] OP_ACC  = 3'd0;
  localparam logic [2:0] OP_CLR  = 3'd1;
  localparam logic [2:0] OP_RD   = 3'd2;
  localparam logic [2:0] OP_MAX  = 3'd3;
  localparam logic [2:0] OP_NEXT = 3'd4;
  localparam logic [2:0] OP_REW  = 3'd5;
  localparam logic [2:0] OP_RST  = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_COL = 2'd1;
  localparam logic [1:0] ST_BAD_ROW = 2'd2;

  // Result kinds
  localparam logic [2:0] E_ERR  = 3'd0;
  localparam logic [2:0] E_CLR  = 3'd1;
  localparam logic [2:0] E_AVG  = 3'd2;
  localparam logic [2:0] E_MAX  = 3'd3;
  localparam logic [2:0] E_WALK = 3'd4;
  localparam logic [2:0] E_WEND = 3'd5;

  // Memory write kinds
  localparam logic [1:0] WR_ACC    = 2'd0;
  localparam logic [1:0] WR_CLRCNT = 2'd1;
  localparam logic [1:0] WR_ZERO   = 2'd2;

  // Memory address sources
  localparam logic [1:0] A_ITEM = 2'd0;
  localparam logic [1:0] A_IDX  = 2'd1;
  localparam logic [1:0] A_CUR  = 2'd2;

  // Configuration register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [2:0]              op;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
    logic                    count_row;
  } in_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row_index;
    logic [COL_W-1:0]        column_index;
    logic signed [VAL_W-1:0] average;
    logic [CNT_W-1:0]        hit_count;
    logic                    found;
    logic                    last;
    logic [1:0]              status;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0]                cnt;
    logic [NUM_COLS-1:0][SUM_W-1:0]  sums;
  } row_t;

  typedef struct packed {
    logic       load;
    logic       mem_rd;
    logic       mem_wr;
    logic [1:0] wr_kind;
    logic [1:0] addr_sel;
    logic       div_start;
    logic       emit;
    logic [2:0] emit_kind;
    logic       idx_clr;
    logic       idx_inc;
    logic       col_clr;
    logic       col_inc;
    logic       cur_clr;
    logic       cur_inc;
    logic       best_clr;
    logic       best_upd;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       err;
    logic       idx_end;
    logic       idx_wipe_last;
    logic       cur_end;
    logic       cnt_zero;
    logic       col_last;
    logic       div_done;
  } sts_t;

endpackage

### design/igat_div.sv
module igat_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [igat_pkg::SUM_W-1:0]   sum,
  input  logic [igat_pkg::CNT_W-1:0]          divisor,
  output logic                                done,
  output logic signed [igat_pkg::VAL_W-1:0]   avg
);

  logic                              busy_r;
  logic                              done_r;
  logic [igat_pkg::STEP_W-1:0]       step_r;
  logic [igat_pkg::SUM_W-1:0]        dvd_r;
  logic [igat_pkg::CNT_W-1:0]        dvs_r;
  logic [igat_pkg::CNT_W-1:0]        rem_r;
  logic                              neg_r;
  logic [igat_pkg::CNT_W:0]          rem_sh;
  logic                              q_bit;
  logic [igat_pkg::CNT_W:0]          rem_sub;

  // One restoring step per cycle
  always_comb begin
    rem_sh  = {rem_r, dvd_r[igat_pkg::SUM_W-1]};
    q_bit   = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= igat_pkg::DIV_STEPS;
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == igat_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Latch magnitudes on start, then shift in quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= sum[igat_pkg::SUM_W-1];
      dvd_r <= sum[igat_pkg::SUM_W-1] ? (-sum) : sum;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[igat_pkg::SUM_W-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[igat_pkg::CNT_W-1:0] : rem_sh[igat_pkg::CNT_W-1:0];
    end
  end

  // Restore sign and clamp to the 32-bit range
  always_comb begin
    if (neg_r) begin
      if (dvd_r > igat_pkg::SUM_W'(48'h0000_8000_0000)) avg = 32'sh8000_0000;
      else avg = -$signed(dvd_r[igat_pkg::VAL_W-1:0]);
    end else begin
      if (dvd_r > igat_pkg::SUM_W'(48'h0000_7FFF_FFFF)) avg = 32'sh7FFF_FFFF;
      else avg = $signed(dvd_r[igat_pkg::VAL_W-1:0]);
    end
  end

  assign done = done_r;

endmodule

### design/igat_dp.sv
module igat_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  igat_pkg::in_t                in_item,
  input  logic [igat_pkg::RCNT_W-1:0]  rows_cfg,
  input  logic [2:0]                   cols_cfg,
  input  igat_pkg::cmd_t               cmd,
  output igat_pkg::sts_t               sts,
  output logic                         out_valid,
  output igat_pkg::out_t               out_item
);

  igat_pkg::row_t mem [igat_pkg::NUM_ROWS];

  igat_pkg::in_t                  item_r;
  igat_pkg::row_t                 rd_data_r;
  logic [igat_pkg::RCNT_W-1:0]    idx_r;
  logic [igat_pkg::RCNT_W-1:0]    cur_r;
  logic [igat_pkg::COL_W-1:0]     col_r;
  logic                           any_r;
  logic [igat_pkg::ROW_W-1:0]     best_row_r;
  logic signed [igat_pkg::VAL_W-1:0] best_avg_r;
  logic [igat_pkg::CNT_W-1:0]     best_cnt_r;
  logic                           out_valid_r;
  igat_pkg::out_t                 out_r;

  logic [igat_pkg::RCNT_W-1:0]    nr;
  logic [2:0]                     nc;
  logic [igat_pkg::ROW_W-1:0]     addr;
  logic                           row_bad;
  logic                           col_bad;
  logic [igat_pkg::SUM_W:0]       sum_ext;
  logic [igat_pkg::SUM_W-1:0]     sum_new;
  igat_pkg::row_t                 acc_row;
  igat_pkg::row_t                 wr_row;
  logic                           div_done;
  logic signed [igat_pkg::VAL_W-1:0] div_avg;
  logic signed [igat_pkg::VAL_W-1:0] avg_now;
  igat_pkg::out_t                 res;

  // Clamp configuration to usable ranges
  always_comb begin
    nr = rows_cfg;
    if (nr == '0) nr = igat_pkg::RCNT_W'(1);
    if (nr > igat_pkg::RCNT_W'(igat_pkg::NUM_ROWS)) nr = igat_pkg::RCNT_W'(igat_pkg::NUM_ROWS);
    nc = cols_cfg;
    if (nc == '0) nc = 3'd1;
    if (nc > 3'(igat_pkg::NUM_COLS)) nc = 3'(igat_pkg::NUM_COLS);
  end

  assign row_bad = ({1'b0, item_r.row} >= nr);
  assign col_bad = ({1'b0, item_r.column} >= nc);

  // Status back to the controller
  always_comb begin
    sts.op            = item_r.op;
    sts.err           = (item_r.op == igat_pkg::OP_MAX) ? col_bad :
                        (row_bad || (item_r.op != igat_pkg::OP_CLR && col_bad));
    sts.idx_end       = (idx_r >= nr);
    sts.idx_wipe_last = (idx_r[igat_pkg::ROW_W-1:0] == {igat_pkg::ROW_W{1'b1}});
    sts.cur_end       = (cur_r >= nr);
    sts.cnt_zero      = (rd_data_r.cnt == '0);
    sts.col_last      = ({1'b0, col_r} == nc - 3'd1);
    sts.div_done      = div_done;
  end

  // Address select
  always_comb begin
    unique case (cmd.addr_sel)
      igat_pkg::A_IDX: addr = idx_r[igat_pkg::ROW_W-1:0];
      igat_pkg::A_CUR: addr = cur_r[igat_pkg::ROW_W-1:0];
      default:         addr = item_r.row;
    endcase
  end

  // Saturating accumulate into the selected column
  always_comb begin
    sum_ext = {rd_data_r.sums[col_r][igat_pkg::SUM_W-1], rd_data_r.sums[col_r]} +
              {{(igat_pkg::SUM_W-igat_pkg::VAL_W+1){item_r.value[igat_pkg::VAL_W-1]}},
               item_r.value};
    if (sum_ext[igat_pkg::SUM_W] != sum_ext[igat_pkg::SUM_W-1])
      sum_new = sum_ext[igat_pkg::SUM_W] ? {1'b1, {(igat_pkg::SUM_W-1){1'b0}}}
                                         : {1'b0, {(igat_pkg::SUM_W-1){1'b1}}};
    else
      sum_new = sum_ext[igat_pkg::SUM_W-1:0];
    acc_row = rd_data_r;
    acc_row.sums[col_r] = sum_new;
    if (item_r.count_row && rd_data_r.cnt != {igat_pkg::CNT_W{1'b1}})
      acc_row.cnt = rd_data_r.cnt + 1'b1;
  end

  always_comb begin
    unique case (cmd.wr_kind)
      igat_pkg::WR_ACC: wr_row = acc_row;
      igat_pkg::WR_CLRCNT: begin
        wr_row = rd_data_r;
        wr_row.cnt = '0;
      end
      default: wr_row = '0;
    endcase
  end

  // Row memory: one port, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[addr] <= wr_row;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) rd_data_r <= mem[addr];
    else if (cmd.mem_wr && cmd.wr_kind == igat_pkg::WR_ACC) rd_data_r <= acc_row;
  end

  igat_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .sum     ($signed(rd_data_r.sums[col_r])),
    .divisor (rd_data_r.cnt),
    .done    (div_done),
    .avg     (div_avg)
  );

  assign avg_now = (rd_data_r.cnt == '0) ? '0 : div_avg;

  // Item, counters and best-so-far
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cur_r <= '0;
      any_r <= 1'b0;
    end else begin
      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
      if (cmd.cur_clr) cur_r <= '0;
      else if (cmd.cur_inc) cur_r <= cur_r + 1'b1;
      if (cmd.best_clr) any_r <= 1'b0;
      else if (cmd.best_upd) any_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) col_r <= in_item.column;
    else if (cmd.col_clr) col_r <= '0;
    else if (cmd.col_inc) col_r <= col_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.best_upd && (!any_r || avg_now > best_avg_r)) begin
      best_row_r <= idx_r[igat_pkg::ROW_W-1:0];
      best_avg_r <= avg_now;
      best_cnt_r <= rd_data_r.cnt;
    end
  end

  // Form the result word
  always_comb begin
    res = '0;
    res.last = 1'b1;
    unique case (cmd.emit_kind)
      igat_pkg::E_ERR: begin
        res.row_index    = item_r.row;
        res.column_index = (item_r.op == igat_pkg::OP_CLR) ? '0 : item_r.column;
        res.status       = (item_r.op != igat_pkg::OP_MAX && row_bad) ?
                           igat_pkg::ST_BAD_ROW : igat_pkg::ST_BAD_COL;
      end
      igat_pkg::E_CLR: begin
        res.row_index = item_r.row;
      end
      igat_pkg::E_AVG: begin
        res.row_index    = item_r.row;
        res.column_index = col_r;
        res.average      = avg_now;
        res.hit_count    = rd_data_r.cnt;
        res.found        = (rd_data_r.cnt != '0);
      end
      igat_pkg::E_MAX: begin
        res.column_index = item_r.column;
        if (any_r) begin
          res.row_index = best_row_r;
          res.average   = best_avg_r;
          res.hit_count = best_cnt_r;
          res.found     = 1'b1;
        end
      end
      igat_pkg::E_WALK: begin
        res.row_index    = cur_r[igat_pkg::ROW_W-1:0];
        res.column_index = col_r;
        res.average      = avg_now;
        res.hit_count    = rd_data_r.cnt;
        res.found        = 1'b1;
        res.last         = sts.col_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### design/igat_ctrl.sv
module igat_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  igat_pkg::sts_t  sts,
  output igat_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WIPE   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_ACC    = 4'd3;
  localparam logic [3:0] S_DSTART = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_CLRROW = 4'd6;
  localparam logic [3:0] S_MRD    = 4'd7;
  localparam logic [3:0] S_MCHK   = 4'd8;
  localparam logic [3:0] S_MDIV   = 4'd9;
  localparam logic [3:0] S_WRD    = 4'd10;
  localparam logic [3:0] S_WCHK   = 4'd11;
  localparam logic [3:0] S_WDS    = 4'd12;
  localparam logic [3:0] S_WDIV   = 4'd13;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      // Zero one row per cycle
      S_WIPE: begin
        cmd.mem_wr   = 1'b1;
        cmd.wr_kind  = igat_pkg::WR_ZERO;
        cmd.addr_sel = igat_pkg::A_IDX;
        cmd.idx_inc  = 1'b1;
        if (sts.idx_wipe_last) state_nxt = S_IDLE;
      end
      S_DEC: begin
        unique case (sts.op)
          igat_pkg::OP_ACC, igat_pkg::OP_CLR, igat_pkg::OP_RD: begin
            if (sts.err) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = igat_pkg::E_ERR;
              state_nxt     = S_IDLE;
            end else begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_sel = igat_pkg::A_ITEM;
              if (sts.op == igat_pkg::OP_ACC) state_nxt = S_ACC;
              else if (sts.op == igat_pkg::OP_CLR) state_nxt = S_CLRROW;
              else state_nxt = S_DSTART;
            end
          end
          igat_pkg::OP_MAX: begin
            if (sts.err) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = igat_pkg::E_ERR;
              state_nxt     = S_IDLE;
            end else begin
              cmd.idx_clr  = 1'b1;
              cmd.best_clr = 1'b1;
              state_nxt    = S_MRD;
            end
          end
          igat_pkg::OP_NEXT: state_nxt = S_WRD;
          igat_pkg::OP_REW: begin
            cmd.cur_clr = 1'b1;
            state_nxt   = S_IDLE;
          end
          igat_pkg::OP_RST: begin
            cmd.idx_clr = 1'b1;
            cmd.cur_clr = 1'b1;
            state_nxt   = S_WIPE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      // Write back the updated sum and count
      S_ACC: begin
        cmd.mem_wr   = 1'b1;
        cmd.wr_kind  = igat_pkg::WR_ACC;
        cmd.addr_sel = igat_pkg::A_ITEM;
        state_nxt    = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = igat_pkg::E_AVG;
          state_nxt     = S_IDLE;
        end
      end
      S_CLRROW: begin
        cmd.mem_wr    = 1'b1;
        cmd.wr_kind   = igat_pkg::WR_CLRCNT;
        cmd.addr_sel  = igat_pkg::A_ITEM;
        cmd.emit      = 1'b1;
        cmd.emit_kind = igat_pkg::E_CLR;
        state_nxt     = S_IDLE;
      end
      // Max search: visit rows in order
      S_MRD: begin
        if (sts.idx_end) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = igat_pkg::E_MAX;
          state_nxt     = S_IDLE;
        end else begin
          cmd.mem_rd   = 1'b1;
          cmd.addr_sel = igat_pkg::A_IDX;
          state_nxt    = S_MCHK;
        end
      end
      S_MCHK: begin
        if (sts.cnt_zero) begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_MRD;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_MDIV;
        end
      end
      S_MDIV: begin
        if (sts.div_done) begin
          cmd.best_upd = 1'b1;
          cmd.idx_inc  = 1'b1;
          state_nxt    = S_MRD;
        end
      end
      // Walk: skip unused rows, then emit one word per column
      S_WRD: begin
        if (sts.cur_end) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = igat_pkg::E_WEND;
          state_nxt     = S_IDLE;
        end else begin
          cmd.mem_rd   = 1'b1;
          cmd.addr_sel = igat_pkg::A_CUR;
          state_nxt    = S_WCHK;
        end
      end
      S_WCHK: begin
        if (sts.cnt_zero) begin
          cmd.cur_inc = 1'b1;
          state_nxt   = S_WRD;
        end else begin
          cmd.col_clr = 1'b1;
          state_nxt   = S_WDS;
        end
      end
      S_WDS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WDIV;
      end
      S_WDIV: begin
        if (sts.div_done) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = igat_pkg::E_WALK;
          if (sts.col_last) begin
            cmd.cur_inc = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            cmd.col_inc = 1'b1;
            state_nxt   = S_WDS;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Reset starts with a clearing pass over the table
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_WIPE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("memory read and write in one cycle");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_DIV || state_r == S_MDIV || state_r == S_WDIV))
    else $error("divider finished outside a wait state");

  a_start_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == S_DIV || state_r == S_MDIV || state_r == S_WDIV))
    else $error("divider started without waiting");

  a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (state_r != S_IDLE && state_r != S_WIPE))
    else $error("result word from idle or clearing");

endmodule

### design/indexed_group_average_table.sv
// Indexed group average table.
// Items enter on the command channel: drive in_item with start high; the item
// is taken at a clock edge where start is high and busy is low. Result words
// leave on out_item, each valid for exactly one cycle while out_valid is high;
// the receiver must take every word, it cannot hold results off.
// Configuration (rows in use at byte 0, columns in use at byte 4) is written
// over the APB port, by the user only while the block is idle; the block
// itself does not enforce this. Reads return the stored values.
// Accumulate reads the row, writes back the new sum and count, then runs the
// 48-step serial divider that forms sum / count; read-average reads and
// divides; clear row reads the row and writes its count back as zero. Max
// search reads every row in use and divides only for used rows. A walk step
// skips unused rows, then divides once per column emitted; rewind resets
// the walk cursor. The one-port row memory, a row per access, paces scans.
// After reset and after a reset item the block sweeps the 1024 table rows,
// one per cycle; busy stays high throughout, and configuration writes are
// accepted during that sweep.
module indexed_group_average_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  igat_pkg::in_t       in_item,
  output logic                out_valid,
  output igat_pkg::out_t      out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [igat_pkg::RCNT_W-1:0] rows_r;
  logic [2:0]                  cols_r;
  logic                        wr_en;
  igat_pkg::cmd_t              cmd;
  igat_pkg::sts_t              sts;

  // Configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= igat_pkg::RCNT_W'(igat_pkg::NUM_ROWS);
      cols_r <= 3'(igat_pkg::NUM_COLS);
    end else if (wr_en) begin
      if (paddr[2] == igat_pkg::REG_ROWS) rows_r <= pwdata[igat_pkg::RCNT_W-1:0];
      else cols_r <= pwdata[2:0];
    end
  end

  always_comb begin
    if (paddr[2] == igat_pkg::REG_ROWS) prdata = {{(32-igat_pkg::RCNT_W){1'b0}}, rows_r};
    else prdata = {29'b0, cols_r};
  end

  igat_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  igat_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .rows_cfg  (rows_r),
    .cols_cfg  (cols_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### tb/indexed_group_average_table_checker.sv
`timescale 1ns / 1ps

module indexed_group_average_table_checker
  import igat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_t         in_item,
  input  logic        out_valid,
  input  out_t        out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          checked
);

  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;

  longint    sums [NUM_ROWS][NUM_COLS];
  int        counts [NUM_ROWS];
  int        cursor;
  logic [10:0] rows_reg;
  logic [2:0]  cols_reg;
  out_t      expected_words[$];

  assign pending = expected_words.size();

  function automatic int rows_eff();
    if (rows_reg < 1) return 1;
    if (rows_reg > NUM_ROWS) return NUM_ROWS;
    return rows_reg;
  endfunction

  function automatic int cols_eff();
    int lim;
    lim = (NUM_COLS < 4) ? NUM_COLS : 4;
    if (cols_reg < 1) return 1;
    if (cols_reg > lim) return lim;
    return cols_reg;
  endfunction

  function automatic longint row_average(int r, int c);
    longint q;
    if (counts[r] == 0) return 0;
    q = sums[r][c] / longint'(counts[r]);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic void push_word(int r, int c, longint avg, int cnt, bit fnd, bit lst,
                                    logic [1:0] st);
    out_t w;
    w.row_index    = r[ROW_W-1:0];
    w.column_index = c[COL_W-1:0];
    w.average      = avg[31:0];
    w.hit_count    = cnt[CNT_W-1:0];
    w.found        = fnd;
    w.last         = lst;
    w.status       = st;
    expected_words.push_back(w);
  endfunction

  function automatic void clear_table();
    foreach (sums[i, j]) sums[i][j] = 0;
    foreach (counts[i]) counts[i] = 0;
    cursor = 0;
  endfunction

  // Work out the words that one accepted item produces and update the table
  function automatic void predict_item(in_t it);
    int nr, nc, r, c, best;
    logic [1:0] st;
    longint s, bv, a;
    bit any;
    nr = rows_eff();
    nc = cols_eff();
    r  = it.row;
    c  = it.column;
    st = ST_OK;
    case (it.op)
      OP_ACC, OP_CLR, OP_RD: begin
        if (r >= nr) st = ST_BAD_ROW;
        else if (it.op != OP_CLR && c >= nc) st = ST_BAD_COL;
        if (st != ST_OK) begin
          push_word(r, (it.op == OP_CLR) ? 0 : c, 0, 0, 0, 1, st);
        end else if (it.op == OP_CLR) begin
          counts[r] = 0;
          push_word(r, 0, 0, 0, 0, 1, ST_OK);
        end else begin
          if (it.op == OP_ACC) begin
            s = sums[r][c] + longint'(it.value);
            if (s > SUM_HI) s = SUM_HI;
            if (s < SUM_LO) s = SUM_LO;
            sums[r][c] = s;
            if (it.count_row && counts[r] < 65535) counts[r]++;
          end
          push_word(r, c, row_average(r, c), counts[r], counts[r] != 0, 1, ST_OK);
        end
      end
      OP_MAX: begin
        if (c >= nc) begin
          push_word(r, c, 0, 0, 0, 1, ST_BAD_COL);
        end else begin
          any = 0;
          best = 0;
          bv = 0;
          for (int i = 0; i < nr; i++) begin
            if (counts[i] != 0) begin
              a = row_average(i, c);
              if (!any || a > bv) begin
                any = 1;
                best = i;
                bv = a;
              end
            end
          end
          if (!any) push_word(0, c, 0, 0, 0, 1, ST_OK);
          else push_word(best, c, bv, counts[best], 1, 1, ST_OK);
        end
      end
      OP_NEXT: begin
        while (cursor < nr && counts[cursor] == 0) cursor++;
        if (cursor >= nr) begin
          push_word(0, 0, 0, 0, 0, 1, ST_OK);
        end else begin
          for (int k = 0; k < nc; k++)
            push_word(cursor, k, row_average(cursor, k), counts[cursor], 1, k + 1 == nc,
                      ST_OK);
          cursor++;
        end
      end
      OP_REW: cursor = 0;
      OP_RST: clear_table();
      default: ;
    endcase
  endfunction

  // Track register writes, predict accepted items, compare result words
  always @(posedge clk) begin
    out_t w;
    if (!rst_n) begin
      clear_table();
      rows_reg <= 11'd1024;
      cols_reg <= 3'd4;
      errors   <= 0;
      checked  <= 0;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_COLS) cols_reg <= pwdata[2:0];
        else rows_reg <= pwdata[10:0];
      end
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result word %p", out_item);
        end else begin
          w = expected_words.pop_front();
          checked <= checked + 1;
          if (w.row_index != out_item.row_index || w.column_index != out_item.column_index ||
              w.average != out_item.average || w.hit_count != out_item.hit_count ||
              w.found != out_item.found || w.last != out_item.last ||
              w.status != out_item.status) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: expected %p, got %p", w, out_item);
          end
        end
      end
      if (start && !busy) predict_item(in_item);
    end
  end

endmodule

### tb/indexed_group_average_table_tb.sv
`timescale 1ns / 1ps

module indexed_group_average_table_tb;
  import igat_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  in_t         in_item = '0;
  logic        out_valid;
  out_t        out_item;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors, pending, checked;
  int items_sent;
  int idle_pct;
  int rows_set;

  always #1 clk = ~clk;

  indexed_group_average_table i_dut (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  indexed_group_average_table_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending, .checked
  );

  // Hand one word to the block, then idle at random
  task automatic send(logic [2:0] op, int row, int col, logic [31:0] val, bit bump);
    in_t it;
    it.op        = op;
    it.row       = row[ROW_W-1:0];
    it.column    = col[COL_W-1:0];
    it.value     = val;
    it.count_row = bump;
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Hold off until every expected word is back and the block is quiet
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, int val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ROWS) rows_set = (val < 1) ? 1 : (val > NUM_ROWS) ? NUM_ROWS : val;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 32'h6_0000) - 32'h3_0000;
    endcase
  endfunction

  // Mostly well-formed traffic on rows in use, with some out of range and noise
  task automatic run_random(int n);
    int p, row, lim;
    logic [2:0] op;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(0, 99);
      if (p < 42) op = OP_ACC;
      else if (p < 62) op = OP_RD;
      else if (p < 70) op = OP_CLR;
      else if (p < 78) op = OP_MAX;
      else if (p < 92) op = OP_NEXT;
      else if (p < 96) op = OP_REW;
      else if (p < 97) op = OP_RST;
      else op = 3'd7;
      lim = (rows_set + 1 < 40) ? rows_set + 1 : 40;
      row = ($urandom_range(0, 99) < 80) ? $urandom_range(0, lim) : $urandom_range(0, 1023);
      send(op, row, $urandom_range(0, 3), pick_value(), $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    #20_000_000;
    $display("indexed_group_average_table_tb failed");
    $finish;
  end

  initial begin
    items_sent = 0;
    idle_pct   = 31;
    rows_set   = NUM_ROWS;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Saturating averages, truncation toward zero, extreme rows and columns
    send(OP_ACC, 0, 0, 32'h7FFF_FFFF, 1);
    send(OP_ACC, 0, 0, 32'h7FFF_FFFF, 0);
    send(OP_ACC, 1, 1, 32'h8000_0000, 1);
    send(OP_ACC, 1, 1, 32'h8000_0000, 0);
    send(OP_ACC, 1023, 3, -5, 1);
    send(OP_ACC, 1023, 3, 2, 1);
    send(OP_RD, 2, 0, 0, 0);
    send(OP_RD, 0, 0, 0, 0);
    send(OP_MAX, 0, 0, 0, 0);
    send(OP_MAX, 0, 1, 0, 0);
    send(OP_MAX, 0, 2, 0, 0);
    repeat (4) send(OP_NEXT, 0, 0, 0, 0);
    send(OP_REW, 0, 0, 0, 0);
    send(OP_NEXT, 0, 0, 0, 0);
    send(OP_CLR, 1, 2, 0, 0);
    send(OP_RD, 1, 1, 0, 0);
    send(3'd7, 1023, 3, 32'hFFFF_FFFF, 1);

    // Range checks against a narrow table
    cfg_write(REG_ROWS, 8);
    cfg_write(REG_COLS, 2);
    send(OP_ACC, 9, 0, 1, 1);
    send(OP_ACC, 3, 3, 1, 1);
    send(OP_CLR, 9, 3, 0, 0);
    send(OP_MAX, 900, 3, 0, 0);
    send(OP_MAX, 900, 0, 0, 0);

    // Register extremes, then a table wipe and a search on an empty table
    cfg_write(REG_ROWS, 0);
    cfg_write(REG_COLS, 0);
    send(OP_ACC, 1, 0, 3, 1);
    send(OP_NEXT, 0, 0, 0, 0);
    cfg_write(REG_ROWS, 2047);
    cfg_write(REG_COLS, 7);
    send(OP_RST, 0, 0, 0, 0);
    send(OP_MAX, 5, 1, 0, 0);

    // Random traffic in three idling regimes
    cfg_write(REG_ROWS, 16);
    cfg_write(REG_COLS, 3);
    run_random(55);
    drain();
    run_random(55);
    idle_pct = 74;
    cfg_write(REG_ROWS, 1024);
    cfg_write(REG_COLS, 4);
    run_random(100);
    idle_pct = 0;
    cfg_write(REG_ROWS, 5);
    cfg_write(REG_COLS, 1);
    run_random(70);

    drain();
    $display("sent %0d items over several table shapes and idling regimes", items_sent);
    $display("checked %0d result words, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("indexed_group_average_table_tb passed");
    end else begin
      $display("indexed_group_average_table_tb failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/igat_pkg.sv
design/igat_div.sv
design/igat_dp.sv
design/igat_ctrl.sv
design/indexed_group_average_table.sv
tb/indexed_group_average_table_checker.sv
tb/indexed_group_average_table_tb.sv
